[sv/sweep_point_generator_top_macros.svh]
// ----------------------------------------------------------------------------
// sweep point generator assertion macros
// concurrent checks on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SWEEP_POINT_GENERATOR_TOP_MACROS_SVH
`define SWEEP_POINT_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define SPG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/spg_pkg.sv]
// ----------------------------------------------------------------------------
// spg_pkg
// types and codes shared by the sweep point generator modules
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_SWEEP_KIND  = 3'd0,
    REG_START_FREQ  = 3'd1,
    REG_STOP_FREQ   = 3'd2,
    REG_START_AMP   = 3'd3,
    REG_STOP_AMP    = 3'd4,
    REG_POINT_COUNT = 3'd5,
    REG_GEO_SPACING = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG_INIT,
    ST_LOG_MUL,
    ST_LOG_ADJ,
    ST_LOG_DONE,
    ST_INTERP_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_INTERP_FIN,
    ST_SEARCH,
    ST_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    JOB_START_LOG,
    JOB_STOP_LOG,
    JOB_MID_LOG
  } log_job_t;

  typedef struct packed {
    logic        sweep_kind;
    logic [31:0] start_freq;
    logic [31:0] stop_freq;
    logic [15:0] start_amp;
    logic [15:0] stop_amp;
    logic [15:0] point_count;
    logic        geo_spacing;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] magnitude_in;
    logic signed [31:0] phase_in;
    logic signed [31:0] in_phase_in;
    logic signed [31:0] quadrature_in;
    logic signed [31:0] noise_in;
  } in_req_t;

  typedef struct packed {
    logic               recorded;
    logic [15:0]        point_index;
    logic [31:0]        frequency;
    logic [15:0]        amplitude;
    logic signed [31:0] magnitude;
    logic signed [31:0] phase;
    logic signed [31:0] in_phase;
    logic signed [31:0] quadrature;
    logic signed [31:0] noise;
    logic               running;
    logic               osc_enable;
  } out_res_t;

endpackage

[sv/spg_div.sv]
// ----------------------------------------------------------------------------
// spg_div
// restoring divider by a 16-bit divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spg_div #(
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CntW = $clog2(DW + 1);

  logic [15:0]   rem;
  logic [DW-1:0] quo;
  logic [CntW-1:0] cnt;
  logic [16:0]   rem_sh;
  logic          ge;
  logic [15:0]   rem_next;

  always_comb begin
    rem_sh   = {rem, quo[DW-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_next = ge ? 16'(rem_sh - {1'b0, divisor}) : rem_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CntW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[sv/spg_core.sv]
// ----------------------------------------------------------------------------
// spg_core
// sweep sequencer: command decode, log2 by squaring, interpolation, search
// ----------------------------------------------------------------------------
`include "sweep_point_generator_top_macros.svh"

module spg_core #(
  parameter int LOG_FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  spg_pkg::cfg_t     cfg,
  input  logic              start,
  input  spg_pkg::in_req_t  req,
  output logic              idle,
  output logic              done,
  input  logic              take,
  output spg_pkg::out_res_t res
);

  localparam int EW   = 5;
  localparam int LW   = EW + LOG_FRAC_BITS;
  localparam int IW   = (LW > 32) ? LW : 32;
  localparam int PW   = IW + 32;
  localparam int DW   = IW + 17;
  localparam int CntW = $clog2(LOG_FRAC_BITS + 1);

  spg_pkg::core_state_t state, state_next;
  spg_pkg::log_job_t    job;

  logic        sweep_active;
  logic [15:0] current_point;
  logic [15:0] i_r;
  logic [15:0] d_r;
  logic [IW-1:0] ia;
  logic [IW-1:0] ib;
  logic [IW-1:0] q_r;
  logic [IW-1:0] lt;
  logic        log_mode;
  logic        kind_r;
  logic [31:0] lx;
  logic [31:0] m;
  logic [EW-1:0] e_r;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [CntW-1:0] cnt;
  logic [PW-1:0] prod;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] mid_r;

  logic          rec_step;
  logic          use_log;
  logic [15:0]   pc_m1;
  spg_pkg::out_res_t res_init;
  logic [EW-1:0] lead_e;
  logic [31:0]   m_init;
  logic [31:0]   m_adj;
  logic          sq_sel;
  logic          div_start;
  logic [IW-1:0] mul_a;
  logic [31:0]   mul_b;
  logic [PW-1:0] mul_p;
  logic          dir_up;
  logic [IW-1:0] diff;
  logic [IW-1:0] lv;
  logic [IW-1:0] r_val;
  logic [32:0]   span;
  logic [31:0]   mid;
  logic [DW-1:0] dividend;
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] quot;

  // command decode
  always_comb begin
    pc_m1    = cfg.point_count - 16'd1;
    rec_step = (req.mode == spg_pkg::MODE_STEP) && sweep_active &&
               (current_point < cfg.point_count);
    use_log  = !cfg.sweep_kind && cfg.geo_spacing && (cfg.start_freq != 32'd0) &&
               (cfg.stop_freq != 32'd0) && (current_point != 16'd0) &&
               (current_point != pc_m1);
    res_init = '0;
    unique case (req.mode)
      spg_pkg::MODE_START: begin
        res_init.running = 1'b1;
        if (!cfg.sweep_kind) begin
          res_init.frequency = cfg.start_freq;
        end else begin
          res_init.amplitude = cfg.start_amp;
        end
      end
      spg_pkg::MODE_STEP: begin
        if (rec_step) begin
          res_init.recorded    = 1'b1;
          res_init.point_index = current_point;
          res_init.magnitude   = req.magnitude_in;
          res_init.phase       = req.phase_in;
          res_init.in_phase    = req.in_phase_in;
          res_init.quadrature  = req.quadrature_in;
          res_init.noise       = req.noise_in;
          res_init.running     = 1'b1;
        end
      end
      spg_pkg::MODE_STOP: res_init.running = 1'b0;
      default: res_init.running = sweep_active;
    endcase
    res_init.osc_enable = res_init.running;
  end

  // datapath
  always_comb begin
    lead_e = '0;
    for (int k = 0; k < 32; k++) begin
      if (lx[k]) lead_e = EW'(k);
    end
    m_init   = lx << (EW'(31) - lead_e);
    m_adj    = prod[63] ? prod[63:32] : prod[62:31];
    dir_up   = ib >= ia;
    diff     = dir_up ? (ib - ia) : (ia - ib);
    mul_a    = sq_sel ? IW'(m) : diff;
    mul_b    = sq_sel ? m : 32'(i_r);
    mul_p    = PW'(mul_a) * PW'(mul_b);
    lv       = IW'({e_r, frac});
    r_val    = dir_up ? (ia + q_r) : (ia - q_r);
    span     = {1'b0, hi} - {1'b0, lo} + 33'd1;
    mid      = 32'({1'b0, lo} + (span >> 1));
    dividend = DW'(prod[IW+15:0]) + DW'(d_r[15:1]);
  end

  spg_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (d_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      spg_pkg::ST_IDLE: begin
        if (start) begin
          if (rec_step) begin
            state_next = use_log ? spg_pkg::ST_LOG_INIT : spg_pkg::ST_INTERP_MUL;
          end else begin
            state_next = spg_pkg::ST_DONE;
          end
        end
      end
      spg_pkg::ST_LOG_INIT: state_next = spg_pkg::ST_LOG_MUL;
      spg_pkg::ST_LOG_MUL:  state_next = spg_pkg::ST_LOG_ADJ;
      spg_pkg::ST_LOG_ADJ: begin
        state_next = (cnt == CntW'(1)) ? spg_pkg::ST_LOG_DONE : spg_pkg::ST_LOG_MUL;
      end
      spg_pkg::ST_LOG_DONE: begin
        unique case (job)
          spg_pkg::JOB_START_LOG: state_next = spg_pkg::ST_LOG_INIT;
          spg_pkg::JOB_STOP_LOG:  state_next = spg_pkg::ST_INTERP_MUL;
          default:                state_next = spg_pkg::ST_SEARCH;
        endcase
      end
      spg_pkg::ST_INTERP_MUL: begin
        state_next = (d_r == 16'd0) ? spg_pkg::ST_INTERP_FIN : spg_pkg::ST_DIV_START;
      end
      spg_pkg::ST_DIV_START: state_next = spg_pkg::ST_DIV_WAIT;
      spg_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = spg_pkg::ST_INTERP_FIN;
      end
      spg_pkg::ST_INTERP_FIN: begin
        state_next = log_mode ? spg_pkg::ST_SEARCH : spg_pkg::ST_DONE;
      end
      spg_pkg::ST_SEARCH: begin
        state_next = (lo < hi) ? spg_pkg::ST_LOG_INIT : spg_pkg::ST_DONE;
      end
      spg_pkg::ST_DONE: begin
        if (take) state_next = spg_pkg::ST_IDLE;
      end
      default: state_next = spg_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    idle      = (state == spg_pkg::ST_IDLE);
    done      = (state == spg_pkg::ST_DONE);
    sq_sel    = (state == spg_pkg::ST_LOG_MUL);
    div_start = (state == spg_pkg::ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spg_pkg::ST_IDLE;
      sweep_active  <= 1'b0;
      current_point <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        spg_pkg::ST_IDLE: begin
          if (start) begin
            res    <= res_init;
            kind_r <= cfg.sweep_kind;
            unique case (req.mode)
              spg_pkg::MODE_START: begin
                current_point <= '0;
                sweep_active  <= 1'b1;
              end
              spg_pkg::MODE_STEP: begin
                if (sweep_active && !rec_step) sweep_active <= 1'b0;
                if (rec_step) current_point <= current_point + 16'd1;
              end
              spg_pkg::MODE_STOP: sweep_active <= 1'b0;
              default: ;
            endcase
            i_r      <= current_point;
            d_r      <= pc_m1;
            log_mode <= use_log;
            lx       <= cfg.start_freq;
            job      <= spg_pkg::JOB_START_LOG;
            if (cfg.sweep_kind) begin
              ia <= IW'(cfg.start_amp);
              ib <= IW'(cfg.stop_amp);
            end else begin
              ia <= IW'(cfg.start_freq);
              ib <= IW'(cfg.stop_freq);
            end
          end
        end
        spg_pkg::ST_LOG_INIT: begin
          m    <= m_init;
          e_r  <= lead_e;
          frac <= '0;
          cnt  <= CntW'(LOG_FRAC_BITS);
        end
        spg_pkg::ST_LOG_MUL: prod <= mul_p;
        spg_pkg::ST_LOG_ADJ: begin
          m    <= m_adj;
          frac <= {frac[LOG_FRAC_BITS-2:0], prod[63]};
          cnt  <= cnt - CntW'(1);
        end
        spg_pkg::ST_LOG_DONE: begin
          unique case (job)
            spg_pkg::JOB_START_LOG: begin
              ia  <= lv;
              lx  <= cfg.stop_freq;
              job <= spg_pkg::JOB_STOP_LOG;
            end
            spg_pkg::JOB_STOP_LOG: ib <= lv;
            default: begin
              if (lv <= lt) lo <= mid_r;
              else hi <= mid_r - 32'd1;
            end
          endcase
        end
        spg_pkg::ST_INTERP_MUL: begin
          prod <= mul_p;
          q_r  <= '0;
        end
        spg_pkg::ST_DIV_WAIT: begin
          if (div_done) q_r <= quot[IW-1:0];
        end
        spg_pkg::ST_INTERP_FIN: begin
          if (log_mode) begin
            lt <= r_val;
            lo <= 32'd1;
            hi <= '1;
          end else if (kind_r) begin
            res.amplitude <= r_val[15:0];
          end else begin
            res.frequency <= r_val[31:0];
          end
        end
        spg_pkg::ST_SEARCH: begin
          if (lo < hi) begin
            lx    <= mid;
            mid_r <= mid;
            job   <= spg_pkg::JOB_MID_LOG;
          end else begin
            res.frequency <= lo;
          end
        end
        default: ;
      endcase
    end
  end

  `SPG_ASSERT_NEXT(a_point_advance, start && idle && rec_step,
    current_point == 16'($past(current_point) + 16'd1), "point index did not advance")
  `SPG_ASSERT(a_done_div_idle, done, !div_busy, "divider busy at result")
  `SPG_ASSERT(a_search_low, state == spg_pkg::ST_SEARCH, lo != 32'd0, "search bound at zero")
  `SPG_ASSERT(a_osc_follows, done, res.osc_enable == res.running, "osc enable differs")

endmodule

[sv/sweep_point_generator_top.sv]
// ----------------------------------------------------------------------------
// sweep_point_generator_top
// sweep sequencer for a reference oscillator, one result per request
// ----------------------------------------------------------------------------
// One request at a time. Start, stop, no-op and non-recording steps go
// straight to the result. A linear step runs the bit-serial divider; a
// single-point sweep skips the divider. A geometric step runs the shared
// squaring multiplier for two log2 evaluations, one linear interpolation
// and up to 32 binary search probes, each a further log2 evaluation.
// A new request is taken while the previous result waits at the output.
module sweep_point_generator_top #(
  parameter int LOG_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [spg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [spg_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  spg_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output spg_pkg::out_res_t              out_data
);

  spg_pkg::cfg_t     cfg;
  spg_pkg::out_res_t core_res;
  logic              core_idle;
  logic              core_done;
  logic              load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spg_pkg::REG_SWEEP_KIND:  cfg.sweep_kind  <= cfg_data[0];
        spg_pkg::REG_START_FREQ:  cfg.start_freq  <= cfg_data;
        spg_pkg::REG_STOP_FREQ:   cfg.stop_freq   <= cfg_data;
        spg_pkg::REG_START_AMP:   cfg.start_amp   <= cfg_data[15:0];
        spg_pkg::REG_STOP_AMP:    cfg.stop_amp    <= cfg_data[15:0];
        spg_pkg::REG_POINT_COUNT: cfg.point_count <= cfg_data[15:0];
        spg_pkg::REG_GEO_SPACING: cfg.geo_spacing <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = core_idle;
  assign load     = core_done && (!out_valid || out_ready);

  spg_core #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (in_valid && in_ready),
    .req   (in_data),
    .idle  (core_idle),
    .done  (core_done),
    .take  (load),
    .res   (core_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= core_res;
  end

endmodule
